### design/wrsp_pkg.sv
// shared types, constants and helpers for the wav riff stream parser
`default_nettype none

package wrsp_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] MIN_FMT_LEN = 32'd16;

    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;
    localparam logic [15:0] BITS_16   = 16'd16;
    localparam logic [15:0] BITS_32   = 16'd32;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_CHUNK_HDR = 3'd1,
        PH_FMT_BODY  = 3'd2,
        PH_SKIP      = 3'd3,
        PH_DATA      = 3'd4,
        PH_DONE      = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        OUT_OK        = 3'd0,
        OUT_BAD_TAG   = 3'd1,
        OUT_SHORT_FMT = 3'd2,
        OUT_ZERO_CHAN = 3'd3,
        OUT_UNSUPP    = 3'd4,
        OUT_NO_DATA   = 3'd5
    } outcome_t;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one queue entry: what a single byte leaves for the result side
    typedef struct packed {
        logic        has_sample;
        logic        is_float;
        logic [31:0] raw;
        logic        has_status;
        logic [2:0]  outcome;
        logic [31:0] rate;
    } evt_t;

    // 16-bit pcm to float32 bits, value / 32768
    function automatic logic [31:0] pcm16_to_float(input logic [15:0] raw);
        logic        sign;
        logic [16:0] mag;
        logic [4:0]  e;
        logic [7:0]  expo;
        logic [39:0] shifted;
        sign = raw[15];
        mag = sign ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        e = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (mag[i])
            begin
                e = 5'(i);
            end
        end
        expo = 8'd112 + {3'b0, e};
        shifted = {23'b0, mag} << (5'd23 - e);
        if (mag == 17'd0)
        begin
            pcm16_to_float = 32'd0;
        end
        else
        begin
            pcm16_to_float = {sign, expo, shifted[22:0]};
        end
    endfunction

endpackage

`default_nettype wire

### design/wrsp_front.sv
// byte parser: walks the riff chunks and queues sample and status events
`default_nettype none

module wrsp_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 accept,
    input  wire  [7:0]          byte_value,
    input  wire                 end_of_buffer,
    output logic                push,
    output wrsp_pkg::evt_t      push_data
);
    import wrsp_pkg::*;

    phase_t      phase_reg, phase_next, phase_step;
    logic [4:0]  cnt_reg, cnt_next, cnt_step;
    logic [31:0] tag_reg, tag_next, tag_step;
    logic [31:0] len_reg, len_next, len_step;
    logic [32:0] skip_reg, skip_next, skip_step;
    logic [15:0] fmt_reg, fmt_next, fmt_step;
    logic [15:0] chan_reg, chan_next, chan_step;
    logic [31:0] rate_reg, rate_next, rate_step;
    logic [15:0] swb_reg, swb_next, swb_step;
    logic [17:0] fbi_reg, fbi_next, fbi_step;
    logic [31:0] asm_reg, asm_next, asm_step;
    logic [2:0]  err_reg, err_next, err_step;

    logic        have_sample;
    logic        is_float;
    logic [17:0] frame_len;
    logic [17:0] fbi_inc;
    logic [32:0] skip_dec;
    logic [31:0] byte_shl;
    logic        data_ok;
    logic [2:0]  status_code;

    // byte lane selected by the low bits of the field counter
    assign byte_shl = {24'b0, byte_value} << {cnt_reg[1:0], 3'b000};
    assign skip_dec = (skip_reg != 33'd0) ? skip_reg - 33'd1 : skip_reg;
    assign fbi_inc  = fbi_reg + 18'd1;
    assign is_float = (swb_reg != BITS_16);
    assign frame_len = is_float ? {chan_reg, 2'b00} : {1'b0, chan_reg, 1'b0};
    assign data_ok = ((fmt_reg == FMT_PCM) && (swb_reg == BITS_16)) ||
                     ((fmt_reg == FMT_FLOAT) && (swb_reg == BITS_32));

    // next state of the parse
    always_comb
    begin
        phase_step = phase_reg;
        cnt_step   = cnt_reg;
        tag_step   = tag_reg;
        len_step   = len_reg;
        skip_step  = skip_reg;
        fmt_step   = fmt_reg;
        chan_step  = chan_reg;
        rate_step  = rate_reg;
        swb_step   = swb_reg;
        fbi_step   = fbi_reg;
        asm_step   = asm_reg;
        err_step   = err_reg;
        have_sample = 1'b0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (cnt_reg < 5'd4 || cnt_reg >= 5'd8)
                begin
                    tag_step = {tag_reg[23:0], byte_value};
                end
                cnt_step = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3 && tag_step != TAG_RIFF)
                begin
                    phase_step = PH_DONE;
                    err_step = OUT_BAD_TAG;
                end
                else if (cnt_reg == 5'd11)
                begin
                    if (tag_step != TAG_WAVE)
                    begin
                        phase_step = PH_DONE;
                        err_step = OUT_BAD_TAG;
                    end
                    else
                    begin
                        phase_step = PH_CHUNK_HDR;
                        cnt_step = 5'd0;
                    end
                end
            end
            PH_CHUNK_HDR:
            begin
                if (cnt_reg < 5'd4)
                begin
                    tag_step = {tag_reg[23:0], byte_value};
                end
                else
                begin
                    len_step = ((cnt_reg == 5'd4) ? 32'd0 : len_reg) | byte_shl;
                end
                cnt_step = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                begin
                    cnt_step = 5'd0;
                    if (tag_reg == TAG_FMT)
                    begin
                        if (len_step < MIN_FMT_LEN)
                        begin
                            phase_step = PH_DONE;
                            err_step = OUT_SHORT_FMT;
                        end
                        else
                        begin
                            phase_step = PH_FMT_BODY;
                        end
                    end
                    else if (tag_reg == TAG_DATA)
                    begin
                        if (!data_ok)
                        begin
                            phase_step = PH_DONE;
                            err_step = OUT_UNSUPP;
                        end
                        else if (len_step == 32'd0)
                        begin
                            phase_step = PH_DONE;
                            err_step = OUT_OK;
                        end
                        else
                        begin
                            phase_step = PH_DATA;
                            skip_step = {1'b0, len_step};
                            fbi_step = 18'd0;
                            asm_step = 32'd0;
                        end
                    end
                    else
                    begin
                        // unknown chunk, skip body plus pad byte
                        skip_step = {1'b0, len_step} + {32'b0, len_step[0]};
                        phase_step = (skip_step == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
            end
            PH_FMT_BODY:
            begin
                if (cnt_reg == 5'd0)
                begin
                    fmt_step = {8'b0, byte_value};
                end
                else if (cnt_reg == 5'd1)
                begin
                    fmt_step = {byte_value, fmt_reg[7:0]};
                end
                else if (cnt_reg == 5'd2)
                begin
                    chan_step = {8'b0, byte_value};
                end
                else if (cnt_reg == 5'd3)
                begin
                    chan_step = {byte_value, chan_reg[7:0]};
                end
                else if (cnt_reg < 5'd8)
                begin
                    asm_step = ((cnt_reg == 5'd4) ? 32'd0 : asm_reg) | byte_shl;
                end
                else if (cnt_reg == 5'd14)
                begin
                    swb_step = {8'b0, byte_value};
                end
                else if (cnt_reg == 5'd15)
                begin
                    swb_step = {byte_value, swb_reg[7:0]};
                end
                cnt_step = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    if (chan_reg == 16'd0)
                    begin
                        phase_step = PH_DONE;
                        err_step = OUT_ZERO_CHAN;
                    end
                    else
                    begin
                        rate_step = asm_reg;
                        skip_step = {1'b0, len_reg - MIN_FMT_LEN} + {32'b0, len_reg[0]};
                        cnt_step = 5'd0;
                        phase_step = (skip_step == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_step = skip_dec;
                if (skip_dec == 33'd0)
                begin
                    phase_step = PH_CHUNK_HDR;
                    cnt_step = 5'd0;
                end
            end
            PH_DATA:
            begin
                if (fbi_reg < (is_float ? 18'd4 : 18'd2))
                begin
                    asm_step = ((fbi_reg == 18'd0) ? 32'd0 : asm_reg) |
                               ({24'b0, byte_value} << {fbi_reg[1:0], 3'b000});
                end
                fbi_step = fbi_inc;
                if (fbi_inc >= frame_len)
                begin
                    fbi_step = 18'd0;
                    have_sample = 1'b1;
                end
                skip_step = skip_dec;
                if (skip_dec == 33'd0)
                begin
                    phase_step = PH_DONE;
                    err_step = OUT_OK;
                end
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
    end

    // the final byte returns everything to reset values after reporting
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        fmt_next   = fmt_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        swb_next   = swb_reg;
        fbi_next   = fbi_reg;
        asm_next   = asm_reg;
        err_next   = err_reg;
        if (accept && end_of_buffer)
        begin
            phase_next = PH_HEADER;
            cnt_next   = 5'd0;
            tag_next   = 32'd0;
            len_next   = 32'd0;
            skip_next  = 33'd0;
            fmt_next   = 16'd0;
            chan_next  = 16'd0;
            rate_next  = 32'd0;
            swb_next   = 16'd0;
            fbi_next   = 18'd0;
            asm_next   = 32'd0;
            err_next   = 3'd0;
        end
        else if (accept)
        begin
            phase_next = phase_step;
            cnt_next   = cnt_step;
            tag_next   = tag_step;
            len_next   = len_step;
            skip_next  = skip_step;
            fmt_next   = fmt_step;
            chan_next  = chan_step;
            rate_next  = rate_step;
            swb_next   = swb_step;
            fbi_next   = fbi_step;
            asm_next   = asm_step;
            err_next   = err_step;
        end
    end

    // event toward the result side
    always_comb
    begin
        unique case (phase_step)
            PH_DONE:     status_code = err_step;
            PH_HEADER:   status_code = OUT_BAD_TAG;
            PH_FMT_BODY: status_code = OUT_SHORT_FMT;
            PH_DATA:     status_code = OUT_OK;
            default:     status_code = OUT_NO_DATA;
        endcase
        push = accept && (have_sample || end_of_buffer);
        push_data.has_sample = have_sample;
        push_data.is_float   = is_float;
        push_data.raw        = is_float ? asm_step : {16'b0, asm_step[15:0]};
        push_data.has_status = end_of_buffer;
        push_data.outcome    = status_code;
        push_data.rate       = rate_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= 5'd0;
            tag_reg   <= 32'd0;
            len_reg   <= 32'd0;
            skip_reg  <= 33'd0;
            fmt_reg   <= 16'd0;
            chan_reg  <= 16'd0;
            rate_reg  <= 32'd0;
            swb_reg   <= 16'd0;
            fbi_reg   <= 18'd0;
            asm_reg   <= 32'd0;
            err_reg   <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            fmt_reg   <= fmt_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            swb_reg   <= swb_next;
            fbi_reg   <= fbi_next;
            asm_reg   <= asm_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

### design/wrsp_fifo.sv
// short event queue between the parser and the result stage
`default_nettype none

module wrsp_fifo #(
    parameter int DEPTH = wrsp_pkg::FIFO_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wrsp_pkg::evt_t      push_data,
    input  wire                 pop,
    output wrsp_pkg::evt_t      head,
    output logic                empty,
    output logic                full
);
    import wrsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    evt_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/wrsp_back.sv
// result stage: converts samples and emits sample and status transactions
`default_nettype none

module wrsp_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wrsp_pkg::evt_t      head,
    input  wire                 empty,
    output logic                pop,
    input  wire                 ready,
    output logic                valid,
    output logic                kind,
    output logic                last,
    output logic [31:0]         sample_bits,
    output logic [2:0]          outcome,
    output logic [31:0]         rate_reported
);
    import wrsp_pkg::*;

    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic        last_reg, last_next;
    logic [31:0] bits_reg, bits_next;
    logic [2:0]  outcome_reg, outcome_next;
    logic [31:0] rate_reg, rate_next;
    logic        smp_done_reg, smp_done_next;
    logic        load;

    assign load = !valid_reg || ready;

    always_comb
    begin
        valid_next    = valid_reg && !ready;
        kind_next     = kind_reg;
        last_next     = last_reg;
        bits_next     = bits_reg;
        outcome_next  = outcome_reg;
        rate_next     = rate_reg;
        smp_done_next = smp_done_reg;
        pop           = 1'b0;
        if (load && !empty)
        begin
            valid_next = 1'b1;
            if (head.has_sample && !smp_done_reg)
            begin
                kind_next    = KIND_SAMPLE;
                bits_next    = head.is_float ? head.raw : pcm16_to_float(head.raw[15:0]);
                outcome_next = OUT_OK;
                rate_next    = 32'd0;
                last_next    = !head.has_status;
                // keep the entry when its status still has to follow
                if (head.has_status)
                begin
                    smp_done_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                kind_next     = KIND_STATUS;
                bits_next     = 32'd0;
                outcome_next  = head.outcome;
                rate_next     = head.rate;
                last_next     = 1'b1;
                smp_done_next = 1'b0;
                pop           = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            smp_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            smp_done_reg <= smp_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        last_reg    <= last_next;
        bits_reg    <= bits_next;
        outcome_reg <= outcome_next;
        rate_reg    <= rate_next;
    end

    assign valid         = valid_reg;
    assign kind          = kind_reg;
    assign last          = last_reg;
    assign sample_bits   = bits_reg;
    assign outcome       = outcome_reg;
    assign rate_reported = rate_reg;

endmodule

`default_nettype wire

### design/wav_riff_stream_parser_core.sv
// top level of the wav riff stream parser
//
// input stream: one byte of a wav buffer per transaction, tlast on the final
// byte. output stream: one result per transaction; tuser is the kind
// (0 sample, 1 end-of-buffer status), tlast marks the last result a byte caused.
// the parser front takes one byte per cycle when the event queue has room; a
// byte that yields a sample or a status pushes one event, the result stage
// turns each event into one or two transactions through its output register.
// a result passes from its byte through the event queue and the output register;
// the status that follows a sample on the same byte comes after that sample.
// throughput: one byte per cycle while the queue has room, one result per cycle
// while m_tready is high, bounded by the single output register; a byte giving
// two results needs two transfers, absorbed by the queue (FIFO_DEPTH entries).
// when the receiver stalls, the output holds and the queue fills; input tready
// drops only when the queue is full.
// reset clears the parser to the header phase and empties queue and output.
// after the final byte the parser returns to that state for the next buffer.
`default_nettype none

module wav_riff_stream_parser_core #(
    parameter int FIFO_DEPTH = wrsp_pkg::FIFO_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] byte_value
    input  wire         s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // [31:0] sample_bits, [34:32] outcome,
                                   // [66:35] rate_reported, [71:67] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // final_res
);
    import wrsp_pkg::*;

    evt_t        push_data, head;
    logic        push, pop, empty, full, accept;
    logic [31:0] sample_bits, rate_reported;
    logic [2:0]  outcome;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    wrsp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_value    (s_tdata),
        .end_of_buffer (s_tlast),
        .push          (push),
        .push_data     (push_data)
    );

    wrsp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    wrsp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .ready         (m_tready),
        .valid         (m_tvalid),
        .kind          (m_tuser),
        .last          (m_tlast),
        .sample_bits   (sample_bits),
        .outcome       (outcome),
        .rate_reported (rate_reported)
    );

    assign m_tdata = {5'b0, rate_reported, outcome, sample_bits};

endmodule

`default_nettype wire

### design/wrsp_checker.sv
// port-level checks for the wav riff stream parser, bound to the top level
`default_nettype none

module wrsp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [71:0] m_tdata,
    input wire        m_tuser,
    input wire        m_tlast
);
    import wrsp_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // status is always the last result of its byte and carries no sample
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast && (m_tdata[31:0] == 32'd0))
        else $error("bad status result");

    // a sample carries zero outcome and rate
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SAMPLE) |-> (m_tdata[66:32] == 35'd0))
        else $error("sample result with status fields");

    // a sample that is not last is followed by the status of the same byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == KIND_SAMPLE) && !m_tlast
            |=> m_tvalid && (m_tuser == KIND_STATUS))
        else $error("missing status after sample");

    // padding bits stay clear and the outcome is a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[71:67] == 5'd0) && ((m_tdata[34:32] <= 3'd5)))
        else $error("bad padding or outcome");

endmodule

bind wav_riff_stream_parser_core wrsp_checker u_wrsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/wav_result_checker.sv
// checker that predicts and compares the wav parser result stream
`timescale 1ns / 1ps

module wav_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          results_due
);
    import wrsp_pkg::*;

    typedef struct {
        logic        kind;
        logic [31:0] bits;
        outcome_t    outcome;
        logic [31:0] rate;
        logic        last_of_byte;
    } result_t;

    result_t expected_results[$];
    result_t head;
    int      errors;

    // parser state as the predictor tracks it
    phase_t      ph;
    logic [4:0]  fcount;
    logic [31:0] tag_acc;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate_val;
    logic [15:0] width_bits;
    logic [17:0] frame_idx;
    logic [31:0] assembly;
    outcome_t    err;

    task automatic reset_parser();
        ph = PH_HEADER;
        fcount = 5'd0;
        tag_acc = 32'd0;
        chunk_len = 32'd0;
        skip_left = 33'd0;
        fmt_code = 16'd0;
        chans = 16'd0;
        rate_val = 32'd0;
        width_bits = 16'd0;
        frame_idx = 18'd0;
        assembly = 32'd0;
        err = OUT_OK;
    endtask

    task automatic end_parse(input outcome_t code);
        ph = PH_DONE;
        err = code;
    endtask

    task automatic resume_after(input logic [32:0] rest);
        skip_left = rest;
        fcount = 5'd0;
        ph = (rest == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
    endtask

    // signed 16-bit pcm over 32768 as single precision bits
    function automatic logic [31:0] pcm_to_single(input logic [15:0] raw);
        logic [15:0] m;
        int          s;
        m = raw[15] ? (16'h0 - raw) : raw;
        s = 0;
        if (m == 16'd0)
        begin
            return 32'd0;
        end
        while (!m[15])
        begin
            m = m << 1;
            s++;
        end
        return {raw[15], 8'(127 - s), m[14:0], 8'h00};
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [4:0]  k;
        logic        got;
        logic [31:0] smp;
        int          bps;
        int          frame;
        logic        ok;
        outcome_t    oc;
        result_t     r;
        k = fcount;
        got = 1'b0;
        smp = 32'd0;
        case (ph)
            PH_HEADER:
            begin
                if (k < 4 || k >= 8)
                begin
                    tag_acc = {tag_acc[23:0], b};
                end
                fcount = k + 5'd1;
                if (k == 3 && tag_acc != TAG_RIFF)
                begin
                    end_parse(OUT_BAD_TAG);
                end
                else if (k == 11)
                begin
                    if (tag_acc != TAG_WAVE)
                    begin
                        end_parse(OUT_BAD_TAG);
                    end
                    else
                    begin
                        ph = PH_CHUNK_HDR;
                        fcount = 5'd0;
                    end
                end
            end
            PH_CHUNK_HDR:
            begin
                if (k < 4)
                begin
                    tag_acc = {tag_acc[23:0], b};
                end
                else if (k == 4)
                begin
                    chunk_len = {24'd0, b};
                end
                else
                begin
                    chunk_len = chunk_len | (32'(b) << (8 * (int'(k) - 4)));
                end
                fcount = k + 5'd1;
                if (k == 7)
                begin
                    fcount = 5'd0;
                    if (tag_acc == TAG_FMT)
                    begin
                        if (chunk_len < MIN_FMT_LEN)
                        begin
                            end_parse(OUT_SHORT_FMT);
                        end
                        else
                        begin
                            ph = PH_FMT_BODY;
                        end
                    end
                    else if (tag_acc == TAG_DATA)
                    begin
                        ok = (fmt_code == FMT_PCM && width_bits == BITS_16) ||
                             (fmt_code == FMT_FLOAT && width_bits == BITS_32);
                        if (!ok)
                        begin
                            end_parse(OUT_UNSUPP);
                        end
                        else if (chunk_len == 32'd0)
                        begin
                            end_parse(OUT_OK);
                        end
                        else
                        begin
                            ph = PH_DATA;
                            skip_left = {1'b0, chunk_len};
                            frame_idx = 18'd0;
                            assembly = 32'd0;
                        end
                    end
                    else
                    begin
                        // odd chunks carry a pad byte
                        resume_after({1'b0, chunk_len} + 33'(chunk_len[0]));
                    end
                end
            end
            PH_FMT_BODY:
            begin
                case (k)
                    5'd0: fmt_code = {8'd0, b};
                    5'd1: fmt_code[15:8] = b;
                    5'd2: chans = {8'd0, b};
                    5'd3: chans[15:8] = b;
                    5'd4: assembly = {24'd0, b};
                    5'd5, 5'd6, 5'd7:
                        assembly = assembly | (32'(b) << (8 * (int'(k) - 4)));
                    5'd14: width_bits = {8'd0, b};
                    5'd15: width_bits[15:8] = b;
                    default: ;
                endcase
                fcount = k + 5'd1;
                if (k == 15)
                begin
                    if (chans == 16'd0)
                    begin
                        end_parse(OUT_ZERO_CHAN);
                    end
                    else
                    begin
                        rate_val = assembly;
                        resume_after({1'b0, chunk_len - MIN_FMT_LEN} + 33'(chunk_len[0]));
                    end
                end
            end
            PH_SKIP:
            begin
                if (skip_left != 33'd0)
                begin
                    skip_left = skip_left - 33'd1;
                end
                if (skip_left == 33'd0)
                begin
                    ph = PH_CHUNK_HDR;
                    fcount = 5'd0;
                end
            end
            PH_DATA:
            begin
                bps = (width_bits == BITS_16) ? 2 : 4;
                frame = bps * int'(chans);
                if (frame_idx < bps)
                begin
                    if (frame_idx == 18'd0)
                    begin
                        assembly = 32'd0;
                    end
                    assembly = assembly | (32'(b) << (8 * int'(frame_idx)));
                end
                frame_idx = frame_idx + 18'd1;
                if (int'(frame_idx) >= frame)
                begin
                    frame_idx = 18'd0;
                    got = 1'b1;
                    smp = (bps == 2) ? pcm_to_single(assembly[15:0]) : assembly;
                end
                if (skip_left != 33'd0)
                begin
                    skip_left = skip_left - 33'd1;
                end
                if (skip_left == 33'd0)
                begin
                    end_parse(OUT_OK);
                end
            end
            default: ;
        endcase

        if (got)
        begin
            r.kind = KIND_SAMPLE;
            r.bits = smp;
            r.outcome = OUT_OK;
            r.rate = 32'd0;
            r.last_of_byte = !last;
            expected_results.push_back(r);
        end
        if (last)
        begin
            case (ph)
                PH_DONE:     oc = err;
                PH_HEADER:   oc = OUT_BAD_TAG;
                PH_FMT_BODY: oc = OUT_SHORT_FMT;
                PH_DATA:     oc = OUT_OK;
                default:     oc = OUT_NO_DATA;
            endcase
            r.kind = KIND_STATUS;
            r.bits = 32'd0;
            r.outcome = oc;
            r.rate = rate_val;
            r.last_of_byte = 1'b1;
            expected_results.push_back(r);
            reset_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            reset_parser();
            errors = 0;
            fail_count <= 0;
            results_due <= 0;
        end
        else
        begin
            // results leave through the queue and output register after their byte, so compare first
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual kind %b data %h last %b",
                             $time, m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    head = expected_results.pop_front();
                    check_field("kind", 32'(head.kind), 32'(m_tuser));
                    check_field("sample_bits", head.bits, m_tdata[31:0]);
                    check_field("outcome", 32'(head.outcome), 32'(m_tdata[34:32]));
                    check_field("rate_reported", head.rate, m_tdata[66:35]);
                    check_field("final_res", 32'(head.last_of_byte), 32'(m_tlast));
                    check_field("tdata pad", 32'd0, 32'(m_tdata[71:67]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast);
            end
            fail_count <= errors;
            results_due <= expected_results.size();
        end
    end

endmodule

### tb/wav_riff_stream_parser_core_tb.sv
// testbench top: wav byte stimulus, result stalls and the verdict
`timescale 1ns / 1ps

module wav_riff_stream_parser_core_tb;
    import wrsp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [71:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;
    int          fail_count;
    int          results_due;

    logic [7:0]  wav_bytes[$];
    int          send_quiet = 0;
    int          take_quiet = 0;
    int          bytes_sent = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    wav_riff_stream_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    wav_result_checker result_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // idle cycles before a transaction, with occasional runs of none
    function automatic int next_gap(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(8, 40);
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
        begin
            wav_bytes.push_back(v[8 * i +: 8]);
        end
    endtask

    task automatic push_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--)
        begin
            wav_bytes.push_back(t[8 * i +: 8]);
        end
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            wav_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = next_gap(send_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < wav_bytes.size(); i++)
        begin
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        end
        bytes_sent += wav_bytes.size();
        wav_bytes.delete();
    endtask

    // mostly well formed wav files with random content, some cut or corrupted
    task automatic build_wave();
        logic [31:0] fmt_len;
        logic [31:0] data_len;
        logic [31:0] v;
        logic [15:0] code;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] s16;
        int          pick;
        int          frame_bytes;
        int          nbytes;
        int          start;
        int          idx;
        push_tag(TAG_RIFF);
        push_le($urandom, 4);
        push_tag(TAG_WAVE);
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom_range(0, 7);
            push_le($urandom, 4);
            push_le(v, 4);
            push_random(int'(v) + int'(v[0]));
        end
        // data before any fmt
        if ($urandom_range(0, 7) == 0)
        begin
            push_tag(TAG_DATA);
            push_le(32'd4, 4);
            push_random(4);
        end
        pick = $urandom_range(0, 11);
        if (pick == 0)
            fmt_len = $urandom_range(0, 15);
        else if (pick == 1)
            fmt_len = 32'hFFFF_FFFF;
        else if (pick <= 3)
            fmt_len = $urandom_range(17, 21);
        else
            fmt_len = MIN_FMT_LEN;
        pick = $urandom_range(0, 11);
        if (pick < 6)
        begin
            code = FMT_PCM;
            bits = BITS_16;
        end
        else if (pick < 10)
        begin
            code = FMT_FLOAT;
            bits = BITS_32;
        end
        else
        begin
            code = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
            bits = ($urandom_range(0, 1) == 0) ? 16'(8 * $urandom_range(1, 4)) : 16'($urandom);
        end
        pick = $urandom_range(0, 11);
        if (pick == 0)
            chans = 16'd0;
        else if (pick == 1)
            chans = 16'hFFFF;
        else
            chans = 16'($urandom_range(1, 3));
        push_tag(TAG_FMT);
        push_le(fmt_len, 4);
        push_le(32'(code), 2);
        push_le(32'(chans), 2);
        push_le($urandom, 4);
        push_le($urandom, 4);
        push_le($urandom, 2);
        push_le(32'(bits), 2);
        if (fmt_len == 32'hFFFF_FFFF)
            push_random($urandom_range(0, 6));
        else if (fmt_len > MIN_FMT_LEN)
            push_random(int'(fmt_len) - 16 + int'(fmt_len[0]));

        frame_bytes = ((bits == BITS_32) ? 4 : 2) * int'(chans);
        if (frame_bytes > 0 && frame_bytes <= 12)
            nbytes = frame_bytes * $urandom_range(0, 8);
        else
            nbytes = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            nbytes += $urandom_range(1, 3);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            data_len = 32'd0;
        else if (pick == 1)
            data_len = $urandom;
        else if (pick == 2)
            data_len = $urandom_range(0, nbytes);
        else
            data_len = nbytes;
        push_tag(TAG_DATA);
        push_le(data_len, 4);
        start = wav_bytes.size();
        push_random(nbytes);
        // extreme pcm values at some frame starts
        if (frame_bytes > 0)
        begin
            for (int f = 0; f + 1 < nbytes; f += frame_bytes)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: s16 = 16'h8000;
                        1: s16 = 16'h0000;
                        2: s16 = 16'h7FFF;
                        default: s16 = 16'h0001;
                    endcase
                    wav_bytes[start + f] = s16[7:0];
                    wav_bytes[start + f + 1] = s16[15:8];
                end
            end
        end
        if ($urandom_range(0, 4) == 0)
            push_random($urandom_range(1, 10));

        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            idx = $urandom_range(1, wav_bytes.size());
            while (wav_bytes.size() > idx)
            begin
                void'(wav_bytes.pop_back());
            end
        end
        else if (pick == 1)
        begin
            idx = $urandom_range(0, wav_bytes.size() - 1);
            wav_bytes[idx] = wav_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
    endtask

    initial
    begin
        int gap;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            gap = next_gap(take_quiet);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single byte buffers at both extremes
        wav_bytes.push_back(8'h00);
        send_buffer();
        wav_bytes.push_back(8'hFF);
        send_buffer();
        // wrong riff tag ending on its own last byte
        push_tag(TAG_RIFF ^ 32'h0000_0001);
        send_buffer();
        // wrong wave tag
        push_tag(TAG_RIFF);
        push_le(32'h00FF_00FF, 4);
        push_tag(TAG_WAVE ^ 32'h0000_0001);
        send_buffer();

        while (bytes_sent < 1000)
        begin
            if ($urandom_range(0, 7) == 0)
                push_random($urandom_range(1, 14));
            else
                build_wave();
            send_buffer();
        end
        s_tvalid <= 1'b0;

        do
        begin
            @(posedge clk);
        end
        while (results_due != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && results_due == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
